[hw/rtl/postfix_expression_evaluator_top_assert.svh]
// assertion macros shared by the evaluator checker
// depends on clk and rst_n being visible where a macro is used
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PEE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator check failed");

// next-cycle implication, disabled while in reset
`define PEE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

`endif

[hw/rtl/pee_pkg.sv]
// shared types, constants and microcode table of the postfix evaluator
// no dependencies
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DCNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int UPC_W       = 5;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_BADCH = 3'd4;

    // datapath actions
    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_FETCH     = 4'd1;
    localparam logic [3:0] ACT_RD_TOP    = 4'd2;
    localparam logic [3:0] ACT_LDB_RDNXT = 4'd3;
    localparam logic [3:0] ACT_LD_A      = 4'd4;
    localparam logic [3:0] ACT_ALU       = 4'd5;
    localparam logic [3:0] ACT_WB        = 4'd6;
    localparam logic [3:0] ACT_PUSH      = 4'd7;
    localparam logic [3:0] ACT_SET_BAD   = 4'd8;
    localparam logic [3:0] ACT_SET_UND   = 4'd9;
    localparam logic [3:0] ACT_SET_OVR   = 4'd10;
    localparam logic [3:0] ACT_SET_DVZ   = 4'd11;
    localparam logic [3:0] ACT_DIV_GO    = 4'd12;
    localparam logic [3:0] ACT_LD_Q      = 4'd13;
    localparam logic [3:0] ACT_LD_B      = 4'd14;
    localparam logic [3:0] ACT_EMIT      = 4'd15;

    // jump conditions
    localparam logic [3:0] COND_NEXT     = 4'd0;
    localparam logic [3:0] COND_ALWAYS   = 4'd1;
    localparam logic [3:0] COND_NO_IN    = 4'd2;
    localparam logic [3:0] COND_ERR      = 4'd3;
    localparam logic [3:0] COND_DIGIT    = 4'd4;
    localparam logic [3:0] COND_NOT_OP   = 4'd5;
    localparam logic [3:0] COND_LT2      = 4'd6;
    localparam logic [3:0] COND_IS_DIV   = 4'd7;
    localparam logic [3:0] COND_FULL     = 4'd8;
    localparam logic [3:0] COND_B_ZERO   = 4'd9;
    localparam logic [3:0] COND_DIV_BUSY = 4'd10;
    localparam logic [3:0] COND_NOT_LAST = 4'd11;
    localparam logic [3:0] COND_CNT_ZERO = 4'd12;
    localparam logic [3:0] COND_OUT_FULL = 4'd13;

    // microcode addresses
    localparam logic [UPC_W-1:0] UA_FETCH    = 5'd0;
    localparam logic [UPC_W-1:0] UA_CHK_ERR  = 5'd1;
    localparam logic [UPC_W-1:0] UA_CHK_DIG  = 5'd2;
    localparam logic [UPC_W-1:0] UA_CHK_OP   = 5'd3;
    localparam logic [UPC_W-1:0] UA_CHK_UND  = 5'd4;
    localparam logic [UPC_W-1:0] UA_RD_TOP   = 5'd5;
    localparam logic [UPC_W-1:0] UA_RD_NXT   = 5'd6;
    localparam logic [UPC_W-1:0] UA_LD_A     = 5'd7;
    localparam logic [UPC_W-1:0] UA_ALU      = 5'd8;
    localparam logic [UPC_W-1:0] UA_WB       = 5'd9;
    localparam logic [UPC_W-1:0] UA_PUSH_CHK = 5'd10;
    localparam logic [UPC_W-1:0] UA_PUSH     = 5'd11;
    localparam logic [UPC_W-1:0] UA_SET_BAD  = 5'd12;
    localparam logic [UPC_W-1:0] UA_SET_UND  = 5'd13;
    localparam logic [UPC_W-1:0] UA_SET_OVR  = 5'd14;
    localparam logic [UPC_W-1:0] UA_DIV_CHK  = 5'd15;
    localparam logic [UPC_W-1:0] UA_DIV_GO   = 5'd16;
    localparam logic [UPC_W-1:0] UA_DIV_WAIT = 5'd17;
    localparam logic [UPC_W-1:0] UA_LD_Q     = 5'd18;
    localparam logic [UPC_W-1:0] UA_SET_DVZ  = 5'd19;
    localparam logic [UPC_W-1:0] UA_FIN      = 5'd20;
    localparam logic [UPC_W-1:0] UA_END_ERR  = 5'd21;
    localparam logic [UPC_W-1:0] UA_END_CNT  = 5'd22;
    localparam logic [UPC_W-1:0] UA_END_RD   = 5'd23;
    localparam logic [UPC_W-1:0] UA_END_LDB  = 5'd24;
    localparam logic [UPC_W-1:0] UA_EMIT     = 5'd25;
    localparam logic [UPC_W-1:0] UA_DONE     = 5'd26;
    localparam logic [UPC_W-1:0] UA_END_UND  = 5'd27;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } pee_char_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } pee_result_t;

    typedef struct packed {
        logic [3:0]       act;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
    } pee_uword_t;

    typedef struct packed {
        logic       fetch;
        logic [3:0] act;
    } pee_ctrl_t;

    typedef struct packed {
        logic err;
        logic digit;
        logic is_op;
        logic lt2;
        logic is_div;
        logic full;
        logic b_zero;
        logic div_busy;
        logic last;
        logic cnt_zero;
    } pee_flags_t;

    function automatic pee_uword_t mk_uword(input logic [3:0] act, input logic [3:0] cond,
                                            input logic [UPC_W-1:0] target);
        pee_uword_t w;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store: jump to target when cond holds, else fall through
    function automatic pee_uword_t pee_ucode(input logic [UPC_W-1:0] addr);
        pee_uword_t w;
        unique case (addr)
            UA_FETCH:    w = mk_uword(ACT_FETCH,     COND_NO_IN,    UA_FETCH);
            UA_CHK_ERR:  w = mk_uword(ACT_NONE,      COND_ERR,      UA_FIN);
            UA_CHK_DIG:  w = mk_uword(ACT_NONE,      COND_DIGIT,    UA_PUSH_CHK);
            UA_CHK_OP:   w = mk_uword(ACT_NONE,      COND_NOT_OP,   UA_SET_BAD);
            UA_CHK_UND:  w = mk_uword(ACT_NONE,      COND_LT2,      UA_SET_UND);
            UA_RD_TOP:   w = mk_uword(ACT_RD_TOP,    COND_NEXT,     UA_FETCH);
            UA_RD_NXT:   w = mk_uword(ACT_LDB_RDNXT, COND_NEXT,     UA_FETCH);
            UA_LD_A:     w = mk_uword(ACT_LD_A,      COND_IS_DIV,   UA_DIV_CHK);
            UA_ALU:      w = mk_uword(ACT_ALU,       COND_NEXT,     UA_FETCH);
            UA_WB:       w = mk_uword(ACT_WB,        COND_ALWAYS,   UA_FIN);
            UA_PUSH_CHK: w = mk_uword(ACT_NONE,      COND_FULL,     UA_SET_OVR);
            UA_PUSH:     w = mk_uword(ACT_PUSH,      COND_ALWAYS,   UA_FIN);
            UA_SET_BAD:  w = mk_uword(ACT_SET_BAD,   COND_ALWAYS,   UA_FIN);
            UA_SET_UND:  w = mk_uword(ACT_SET_UND,   COND_ALWAYS,   UA_FIN);
            UA_SET_OVR:  w = mk_uword(ACT_SET_OVR,   COND_ALWAYS,   UA_FIN);
            UA_DIV_CHK:  w = mk_uword(ACT_NONE,      COND_B_ZERO,   UA_SET_DVZ);
            UA_DIV_GO:   w = mk_uword(ACT_DIV_GO,    COND_NEXT,     UA_FETCH);
            UA_DIV_WAIT: w = mk_uword(ACT_NONE,      COND_DIV_BUSY, UA_DIV_WAIT);
            UA_LD_Q:     w = mk_uword(ACT_LD_Q,      COND_ALWAYS,   UA_WB);
            UA_SET_DVZ:  w = mk_uword(ACT_SET_DVZ,   COND_ALWAYS,   UA_FIN);
            UA_FIN:      w = mk_uword(ACT_NONE,      COND_NOT_LAST, UA_FETCH);
            UA_END_ERR:  w = mk_uword(ACT_NONE,      COND_ERR,      UA_EMIT);
            UA_END_CNT:  w = mk_uword(ACT_NONE,      COND_CNT_ZERO, UA_END_UND);
            UA_END_RD:   w = mk_uword(ACT_RD_TOP,    COND_NEXT,     UA_FETCH);
            UA_END_LDB:  w = mk_uword(ACT_LD_B,      COND_NEXT,     UA_FETCH);
            UA_EMIT:     w = mk_uword(ACT_EMIT,      COND_OUT_FULL, UA_EMIT);
            UA_DONE:     w = mk_uword(ACT_NONE,      COND_ALWAYS,   UA_FETCH);
            UA_END_UND:  w = mk_uword(ACT_SET_UND,   COND_ALWAYS,   UA_EMIT);
            default:     w = mk_uword(ACT_NONE,      COND_ALWAYS,   UA_FETCH);
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/postfix_expression_evaluator_top.sv]
// channel   signals                               payload
// char      char_valid / char_ready / char_data   ch[7:0], last
// result    result_valid / result_ready           value[31:0] signed, status[2:0]
//
// one character at a time, for digits, + - *, divide (the single divider resolves one
// quotient bit per cycle) and the sticky-error skip alike
// a last character adds steps to fetch the top and load the result register
// rst_n clears the step counter, stack count, error and result valid; stack is unreset
// a held result register stalls the sequencer in the emit step only
// depends on pee_pkg, pee_seq, pee_dp
module postfix_expression_evaluator_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_ready,
    input  pee_pkg::pee_char_t      char_data,
    output logic                    result_valid,
    input  logic                    result_ready,
    output pee_pkg::pee_result_t    result_data
);
    import pee_pkg::*;

    pee_ctrl_t   ctrl;
    pee_flags_t  flags;
    pee_result_t emit_data;
    pee_result_t result_reg;
    logic        result_valid_reg, result_valid_next;
    logic        out_full;

    assign out_full = result_valid_reg && !result_ready;

    pee_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .out_full   (out_full),
        .flags      (flags),
        .ctrl       (ctrl)
    );

    pee_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .char_data (char_data),
        .flags     (flags),
        .emit_data (emit_data)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (ctrl.act == ACT_EMIT)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.act == ACT_EMIT)
        begin
            result_reg <= emit_data;
        end
    end

    assign char_ready   = ctrl.fetch;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

[hw/rtl/pee_stack.sv]
// operand stack memory: one write port, one registered read port
// depends on pee_pkg
module pee_stack (
    input  logic                                clk,
    input  logic                                we,
    input  logic [pee_pkg::ADDR_W-1:0]          waddr,
    input  logic [pee_pkg::VALUE_WIDTH-1:0]     wdata,
    input  logic                                re,
    input  logic [pee_pkg::ADDR_W-1:0]          raddr,
    output logic [pee_pkg::VALUE_WIDTH-1:0]     rdata
);
    import pee_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pee_div.sv]
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pee_pkg
module pee_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pee_pkg::VALUE_WIDTH-1:0]     dividend,
    input  logic [pee_pkg::VALUE_WIDTH-1:0]     divisor,
    output logic                                busy,
    output logic [pee_pkg::VALUE_WIDTH-1:0]     quotient
);
    import pee_pkg::*;

    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] mag_b_reg, mag_b_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;

    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, mag_b_reg};
    assign fits    = !diff[VALUE_WIDTH];

    always_comb
    begin
        dcnt_next  = dcnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            // magnitudes; the most negative value maps onto itself as unsigned
            dcnt_next  = DCNT_W'(VALUE_WIDTH);
            rem_next   = '0;
            quo_next   = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            mag_b_next = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
            neg_next   = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_next = dcnt_reg - 1'b1;
            rem_next  = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            quo_next  = {quo_reg[VALUE_WIDTH-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else
        begin
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
    end

    assign busy     = (dcnt_reg != '0);
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

[hw/rtl/pee_dp.sv]
// evaluator datapath: character register, stack count, error, operand regs, alu
// depends on pee_pkg, pee_stack, pee_div
module pee_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pee_pkg::pee_ctrl_t      ctrl,
    input  pee_pkg::pee_char_t      char_data,
    output pee_pkg::pee_flags_t     flags,
    output pee_pkg::pee_result_t    emit_data
);
    import pee_pkg::*;

    logic [7:0]             ch_reg;
    logic                   last_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [2:0]             err_reg, err_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] alu_res;
    logic [CNT_W-1:0]       cnt_m1, cnt_m2;
    logic [3:0]             digit_val;

    logic                   stk_we, stk_re;
    logic [ADDR_W-1:0]      stk_waddr, stk_raddr;
    logic [VALUE_WIDTH-1:0] stk_wdata, stk_rdata;

    logic                   div_start, div_busy;
    logic [VALUE_WIDTH-1:0] div_q;

    pee_stack u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    pee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cnt_m2    = cnt_reg - CNT_W'(2);
    assign digit_val = 4'(ch_reg - CH_ZERO);

    assign flags.err      = (err_reg != ST_OK);
    assign flags.digit    = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign flags.is_op    = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS) ||
                            (ch_reg == CH_STAR) || (ch_reg == CH_SLASH);
    assign flags.lt2      = (cnt_reg < CNT_W'(2));
    assign flags.is_div   = (ch_reg == CH_SLASH);
    assign flags.full     = (cnt_reg >= CNT_W'(STACK_DEPTH));
    assign flags.b_zero   = (b_reg == '0);
    assign flags.div_busy = div_busy;
    assign flags.last     = last_reg;
    assign flags.cnt_zero = (cnt_reg == '0);

    always_comb
    begin
        unique case (ch_reg)
            CH_PLUS:  alu_res = a_reg + b_reg;
            CH_MINUS: alu_res = a_reg - b_reg;
            default:  alu_res = a_reg * b_reg;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        stk_we    = 1'b0;
        stk_waddr = cnt_reg[ADDR_W-1:0];
        stk_wdata = r_reg;
        stk_re    = 1'b0;
        stk_raddr = cnt_m1[ADDR_W-1:0];
        div_start = 1'b0;
        unique case (ctrl.act)
            ACT_RD_TOP:
            begin
                stk_re = 1'b1;
            end
            ACT_LDB_RDNXT:
            begin
                b_next    = stk_rdata;
                stk_re    = 1'b1;
                stk_raddr = cnt_m2[ADDR_W-1:0];
            end
            ACT_LD_A:    a_next = stk_rdata;
            ACT_LD_B:    b_next = stk_rdata;
            ACT_ALU:     r_next = alu_res;
            ACT_LD_Q:    r_next = div_q;
            ACT_DIV_GO:  div_start = 1'b1;
            ACT_WB:
            begin
                // result replaces the deeper operand
                stk_we    = 1'b1;
                stk_waddr = cnt_m2[ADDR_W-1:0];
                cnt_next  = cnt_m1;
            end
            ACT_PUSH:
            begin
                stk_we    = 1'b1;
                stk_wdata = VALUE_WIDTH'(digit_val);
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            ACT_SET_BAD: err_next = ST_BADCH;
            ACT_SET_UND: err_next = ST_UNDER;
            ACT_SET_OVR: err_next = ST_OVER;
            ACT_SET_DVZ: err_next = ST_DIVZ;
            ACT_EMIT:
            begin
                cnt_next = '0;
                err_next = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign emit_data.status = err_reg;
    assign emit_data.value  = (err_reg != ST_OK) ? 32'sd0 : 32'(signed'(b_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        if (ctrl.act == ACT_FETCH)
        begin
            ch_reg   <= char_data.ch;
            last_reg <= char_data.last;
        end
    end

endmodule

[hw/rtl/pee_seq.sv]
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on pee_pkg
module pee_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    input  logic                    out_full,
    input  pee_pkg::pee_flags_t     flags,
    output pee_pkg::pee_ctrl_t      ctrl
);
    import pee_pkg::*;

    logic [UPC_W-1:0] upc_reg, upc_next;
    pee_uword_t       uw;
    logic             take;

    assign uw = pee_ucode(upc_reg);

    always_comb
    begin
        unique case (uw.cond)
            COND_NEXT:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_IN:    take = !char_valid;
            COND_ERR:      take = flags.err;
            COND_DIGIT:    take = flags.digit;
            COND_NOT_OP:   take = !flags.is_op;
            COND_LT2:      take = flags.lt2;
            COND_IS_DIV:   take = flags.is_div;
            COND_FULL:     take = flags.full;
            COND_B_ZERO:   take = flags.b_zero;
            COND_DIV_BUSY: take = flags.div_busy;
            COND_NOT_LAST: take = !flags.last;
            COND_CNT_ZERO: take = flags.cnt_zero;
            COND_OUT_FULL: take = out_full;
            default:       take = 1'b0;
        endcase
    end

    assign upc_next = take ? uw.target : (upc_reg + 1'b1);

    // fetch and emit only fire when their handshake side allows it
    always_comb
    begin
        ctrl.fetch = (uw.act == ACT_FETCH);
        ctrl.act   = uw.act;
        if ((uw.act == ACT_FETCH) && !char_valid)
        begin
            ctrl.act = ACT_NONE;
        end
        if ((uw.act == ACT_EMIT) && out_full)
        begin
            ctrl.act = ACT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[hw/rtl/pee_chk.sv]
// port-level checker for the postfix evaluator, bound to the top level
// depends on pee_pkg and postfix_expression_evaluator_top_assert.svh
`include "postfix_expression_evaluator_top_assert.svh"

module pee_chk (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    input  logic                    char_ready,
    input  logic                    result_valid,
    input  logic                    result_ready,
    input  pee_pkg::pee_result_t    result_data
);
    import pee_pkg::*;

    logic err_out;
    logic out_stall;

    assign err_out   = result_valid && (result_data.status != ST_OK);
    assign out_stall = result_valid && !result_ready;

    // char_ready is always low in the cycle after a character is taken
    `PEE_ASSERT_NXT(a_ready_drops, char_valid && char_ready, !char_ready)

    // result is not offered in the same cycle a new character could be taken
    `PEE_ASSERT_IMP(a_emit_busy, $rose(result_valid), !char_ready)

    // failed expressions report zero
    `PEE_ASSERT_IMP(a_err_zero, err_out, result_data.value == 32'sd0)

    `PEE_ASSERT_NXT(a_result_hold, out_stall, result_valid && $stable(result_data))

endmodule

bind postfix_expression_evaluator_top pee_chk u_pee_chk (.*);
